/* hw/rtl/ced_pkg.sv */
// Shared types and constants for the clock time digit editor.
package ced_pkg;

    // Default converter sample width
    localparam int ADC_BITS = 12;

    // Threshold register width and reset values
    localparam int           THR_W        = 12;
    localparam logic [11:0]  LOW_THR_RST  = 12'd300;
    localparam logic [11:0]  HIGH_THR_RST = 12'd3800;

    // Configuration register indexes
    localparam logic CFG_LOW_THR  = 1'b0;
    localparam logic CFG_HIGH_THR = 1'b1;

    // Item kinds
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    // Remote key codes
    localparam logic [7:0] KEY_UP    = 8'h55;
    localparam logic [7:0] KEY_DOWN  = 8'h44;
    localparam logic [7:0] KEY_LEFT  = 8'h4C;
    localparam logic [7:0] KEY_RIGHT = 8'h52;

    // Cursor positions
    localparam logic [2:0] CUR_AMPM     = 3'd0;
    localparam logic [2:0] CUR_HOUR_TEN = 3'd1;
    localparam logic [2:0] CUR_HOUR_ONE = 3'd2;
    localparam logic [2:0] CUR_MIN_TEN  = 3'd3;
    localparam logic [2:0] CUR_MIN_ONE  = 3'd4;
    localparam logic [2:0] CUR_SEC_TEN  = 3'd5;
    localparam logic [2:0] CUR_SEC_ONE  = 3'd6;

    // Time limits
    localparam logic [3:0] HOUR_MIN = 4'd1;
    localparam logic [3:0] HOUR_MAX = 4'd12;
    localparam logic [3:0] HOUR_RST = 4'd12;
    localparam logic [5:0] MS_MIN   = 6'd0;
    localparam logic [5:0] MS_MAX   = 6'd59;

    // Steps
    localparam logic [3:0] STEP_TEN = 4'd10;
    localparam logic [3:0] STEP_ONE = 4'd1;

    // Direction codes
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_LEFT  = 3'd4
    } t_dir;

endpackage

/* hw/rtl/ced_if.sv */
// Input and result channel interfaces of the clock time digit editor.
interface ced_in_if #(
    parameter int ADC_BITS = ced_pkg::ADC_BITS
);
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ADC_BITS-1:0] joy_x;
    logic [ADC_BITS-1:0] joy_y;
    logic [7:0]          key_byte;

    modport source (output valid, kind, joy_x, joy_y, key_byte, input ready);
    modport sink   (input valid, kind, joy_x, joy_y, key_byte, output ready);
endinterface

interface ced_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] cursor;
    logic       pm;
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] applied_direction;

    modport source (output valid, cursor, pm, hours, minutes, seconds, applied_direction,
                    input ready);
    modport sink   (input valid, cursor, pm, hours, minutes, seconds, applied_direction,
                    output ready);
endinterface

/* hw/rtl/clock_time_digit_editor_top.sv */
// Top level of the clock time digit editor: input register, edit logic, result register.
// Path: an item passes through the input register, then the result register, which holds
// it while the result side stalls.
// Throughput: one item per cycle while the result side takes results; the time and cursor
// registers update as an item leaves the input register, so the next item sees them.
// Backpressure: the input is ready while the input register is empty, or the result register is empty or being taken.
// Reset (synchronous, active low): time 12:00:00 AM, cursor at AM/PM, no pending
// direction, thresholds 300 and 3800, both registers empty.
module clock_time_digit_editor_top #(
    parameter int ADC_BITS = ced_pkg::ADC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [ced_pkg::THR_W-1:0] i_cfg_data,
    ced_in_if.sink                 i_in,
    ced_out_if.source              o_out
);

    // Wrapping step: add or subtract d, wrap to lo or hi when out of range
    function automatic logic [5:0] f_step(input logic [5:0] v, input logic inc,
                                          input logic [3:0] d, input logic [5:0] lo,
                                          input logic [5:0] hi);
        logic [6:0] sum;
        logic [5:0] res;
        sum = {1'b0, v} + 7'(d);
        if (inc) begin
            res = (sum > {1'b0, hi}) ? lo : sum[5:0];
        end else begin
            res = ({1'b0, v} < ({1'b0, lo} + 7'(d))) ? hi : (v - 6'(d));
        end
        return res;
    endfunction

    // Configuration registers
    logic [ced_pkg::THR_W-1:0] r_low_thr;
    logic [ced_pkg::THR_W-1:0] r_high_thr;

    // Input register
    logic                r_in_valid;
    logic                r_in_kind;
    logic [ADC_BITS-1:0] r_in_x;
    logic [ADC_BITS-1:0] r_in_y;
    logic [7:0]          r_in_key;

    // Editor state
    logic [2:0]    r_cursor, n_cursor;
    logic          r_pm, n_pm;
    logic [3:0]    r_hours, n_hours;
    logic [5:0]    r_minutes, n_minutes;
    logic [5:0]    r_seconds, n_seconds;
    ced_pkg::t_dir r_pending, n_pending;

    // Result register
    logic          r_out_valid;
    logic [2:0]    r_out_cursor;
    logic          r_out_pm;
    logic [3:0]    r_out_hours;
    logic [5:0]    r_out_minutes;
    logic [5:0]    r_out_seconds;
    ced_pkg::t_dir r_out_dir;

    logic          out_free;
    logic          in_xfer;
    logic          proc;
    ced_pkg::t_dir joy_dir;
    ced_pkg::t_dir dir;
    logic [ADC_BITS-1:0] lo_m;
    logic [ADC_BITS-1:0] hi_m;
    logic [3:0]    step;
    logic          inc;

    // Handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign proc       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Classify the joystick sample against the thresholds
    assign lo_m = ADC_BITS'(r_low_thr);
    assign hi_m = ADC_BITS'(r_high_thr);
    always_comb begin
        if (r_in_x < lo_m) begin
            joy_dir = ced_pkg::DIR_UP;
        end else if (r_in_x > hi_m) begin
            joy_dir = ced_pkg::DIR_DOWN;
        end else if (r_in_y > hi_m) begin
            joy_dir = ced_pkg::DIR_LEFT;
        end else if (r_in_y < lo_m) begin
            joy_dir = ced_pkg::DIR_RIGHT;
        end else begin
            joy_dir = ced_pkg::DIR_NONE;
        end
    end

    // Apply the item to the editor state
    always_comb begin
        n_cursor  = r_cursor;
        n_pm      = r_pm;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_pending = r_pending;
        dir       = ced_pkg::DIR_NONE;
        if (r_in_kind == ced_pkg::KIND_KEY) begin
            case (r_in_key)
                ced_pkg::KEY_UP:    n_pending = ced_pkg::DIR_UP;
                ced_pkg::KEY_DOWN:  n_pending = ced_pkg::DIR_DOWN;
                ced_pkg::KEY_LEFT:  n_pending = ced_pkg::DIR_LEFT;
                ced_pkg::KEY_RIGHT: n_pending = ced_pkg::DIR_RIGHT;
                default:            n_pending = r_pending;
            endcase
        end else begin
            if (r_pending != ced_pkg::DIR_NONE) begin
                dir       = r_pending;
                n_pending = ced_pkg::DIR_NONE;
            end else begin
                dir = joy_dir;
            end
        end

        inc  = (dir == ced_pkg::DIR_UP);
        step = (r_cursor == ced_pkg::CUR_HOUR_TEN || r_cursor == ced_pkg::CUR_MIN_TEN ||
                r_cursor == ced_pkg::CUR_SEC_TEN) ? ced_pkg::STEP_TEN : ced_pkg::STEP_ONE;

        case (dir)
            ced_pkg::DIR_RIGHT: begin
                if (r_cursor < ced_pkg::CUR_SEC_ONE) n_cursor = r_cursor + 3'd1;
            end
            ced_pkg::DIR_LEFT: begin
                if (r_cursor > ced_pkg::CUR_AMPM) n_cursor = r_cursor - 3'd1;
            end
            ced_pkg::DIR_UP, ced_pkg::DIR_DOWN: begin
                case (r_cursor)
                    ced_pkg::CUR_AMPM: n_pm = !r_pm;
                    ced_pkg::CUR_HOUR_TEN, ced_pkg::CUR_HOUR_ONE: begin
                        n_hours = 4'(f_step({2'b00, r_hours}, inc, step,
                                            {2'b00, ced_pkg::HOUR_MIN},
                                            {2'b00, ced_pkg::HOUR_MAX}));
                    end
                    ced_pkg::CUR_MIN_TEN, ced_pkg::CUR_MIN_ONE: begin
                        n_minutes = f_step(r_minutes, inc, step, ced_pkg::MS_MIN,
                                           ced_pkg::MS_MAX);
                    end
                    ced_pkg::CUR_SEC_TEN, ced_pkg::CUR_SEC_ONE: begin
                        n_seconds = f_step(r_seconds, inc, step, ced_pkg::MS_MIN,
                                           ced_pkg::MS_MAX);
                    end
                    default: n_pm = r_pm;
                endcase
            end
            default: n_cursor = r_cursor;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= ced_pkg::LOW_THR_RST;
            r_high_thr <= ced_pkg::HIGH_THR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ced_pkg::CFG_LOW_THR) begin
                r_low_thr <= i_cfg_data;
            end else begin
                r_high_thr <= i_cfg_data;
            end
        end
    end

    // Input register: hold while the item waits, load on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_kind <= i_in.kind;
            r_in_x    <= i_in.joy_x;
            r_in_y    <= i_in.joy_y;
            r_in_key  <= i_in.key_byte;
        end
    end

    // Editor state: advance as an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= ced_pkg::CUR_AMPM;
            r_pm      <= 1'b0;
            r_hours   <= ced_pkg::HOUR_RST;
            r_minutes <= ced_pkg::MS_MIN;
            r_seconds <= ced_pkg::MS_MIN;
            r_pending <= ced_pkg::DIR_NONE;
        end else if (proc) begin
            r_cursor  <= n_cursor;
            r_pm      <= n_pm;
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
            r_pending <= n_pending;
        end
    end

    // Result register: hold until the transfer, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_cursor  <= n_cursor;
            r_out_pm      <= n_pm;
            r_out_hours   <= n_hours;
            r_out_minutes <= n_minutes;
            r_out_seconds <= n_seconds;
            r_out_dir     <= dir;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.cursor            = r_out_cursor;
    assign o_out.pm                = r_out_pm;
    assign o_out.hours             = r_out_hours;
    assign o_out.minutes           = r_out_minutes;
    assign o_out.seconds           = r_out_seconds;
    assign o_out.applied_direction = r_out_dir;

    // Checks
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= ced_pkg::CUR_SEC_ONE)
        else $error("cursor beyond last position");

    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hours >= ced_pkg::HOUR_MIN && r_hours <= ced_pkg::HOUR_MAX)
        else $error("hours out of range");

    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minutes <= ced_pkg::MS_MAX && r_seconds <= ced_pkg::MS_MAX)
        else $error("minutes or seconds out of range");

    a_poll_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_kind == ced_pkg::KIND_POLL |=> r_pending == ced_pkg::DIR_NONE)
        else $error("pending direction survived a poll");

    a_key_no_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_kind == ced_pkg::KIND_KEY |=> r_out_dir == ced_pkg::DIR_NONE)
        else $error("key item reported a direction");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the clock time digit editor: directed and random items.
`timescale 1ns / 100ps

// One edited time as it leaves the block
typedef struct {
    logic [2:0] cursor;
    logic       pm;
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] applied_direction;
} t_time_view;

// Time editor model plus the queue of edited times still owed by the block
class time_edit_scoreboard;
    logic [ced_pkg::THR_W-1:0] low_thr;
    logic [ced_pkg::THR_W-1:0] high_thr;
    logic [2:0]                cursor;
    logic                      pm;
    logic [3:0]                hours;
    logic [5:0]                minutes;
    logic [5:0]                seconds;
    ced_pkg::t_dir             pending;
    t_time_view                due[$];
    int                        errors;
    int                        checked;
    int                        applied;

    function new();
        low_thr  = ced_pkg::LOW_THR_RST;
        high_thr = ced_pkg::HIGH_THR_RST;
        cursor   = ced_pkg::CUR_AMPM;
        pm       = 1'b0;
        hours    = ced_pkg::HOUR_RST;
        minutes  = ced_pkg::MS_MIN;
        seconds  = ced_pkg::MS_MIN;
        pending  = ced_pkg::DIR_NONE;
        errors   = 0;
        checked  = 0;
        applied  = 0;
    endfunction

    // Step a value and fall back to the far end when it leaves the range
    function int wrapped(int value, int delta, int lo, int hi);
        int sum;
        sum = value + delta;
        if (sum < lo || sum > hi)
            return (delta > 0) ? lo : hi;
        return sum;
    endfunction

    // Up (+1) or down (-1) at the digit under the cursor
    function void edit_digit(int sign);
        int ten;
        int one;
        ten = int'(ced_pkg::STEP_TEN) * sign;
        one = int'(ced_pkg::STEP_ONE) * sign;
        case (cursor)
            ced_pkg::CUR_AMPM:     pm = ~pm;
            ced_pkg::CUR_HOUR_TEN:
                hours = 4'(wrapped(hours, ten, ced_pkg::HOUR_MIN, ced_pkg::HOUR_MAX));
            ced_pkg::CUR_HOUR_ONE:
                hours = 4'(wrapped(hours, one, ced_pkg::HOUR_MIN, ced_pkg::HOUR_MAX));
            ced_pkg::CUR_MIN_TEN:
                minutes = 6'(wrapped(minutes, ten, ced_pkg::MS_MIN, ced_pkg::MS_MAX));
            ced_pkg::CUR_MIN_ONE:
                minutes = 6'(wrapped(minutes, one, ced_pkg::MS_MIN, ced_pkg::MS_MAX));
            ced_pkg::CUR_SEC_TEN:
                seconds = 6'(wrapped(seconds, ten, ced_pkg::MS_MIN, ced_pkg::MS_MAX));
            ced_pkg::CUR_SEC_ONE:
                seconds = 6'(wrapped(seconds, one, ced_pkg::MS_MIN, ced_pkg::MS_MAX));
            default: ;
        endcase
    endfunction

    // Advance the model on an accepted item and queue the time it leaves
    function void note_input(logic kind, logic [ced_pkg::ADC_BITS-1:0] x,
                             logic [ced_pkg::ADC_BITS-1:0] y, logic [7:0] key);
        ced_pkg::t_dir dir;
        t_time_view    view;
        dir = ced_pkg::DIR_NONE;
        if (kind == ced_pkg::KIND_KEY) begin
            case (key)
                ced_pkg::KEY_UP:    pending = ced_pkg::DIR_UP;
                ced_pkg::KEY_DOWN:  pending = ced_pkg::DIR_DOWN;
                ced_pkg::KEY_LEFT:  pending = ced_pkg::DIR_LEFT;
                ced_pkg::KEY_RIGHT: pending = ced_pkg::DIR_RIGHT;
                default: ;
            endcase
        end else begin
            // A remote key wins over the joystick
            if (pending != ced_pkg::DIR_NONE) begin
                dir     = pending;
                pending = ced_pkg::DIR_NONE;
            end else if (x < low_thr) begin
                dir = ced_pkg::DIR_UP;
            end else if (x > high_thr) begin
                dir = ced_pkg::DIR_DOWN;
            end else if (y > high_thr) begin
                dir = ced_pkg::DIR_LEFT;
            end else if (y < low_thr) begin
                dir = ced_pkg::DIR_RIGHT;
            end
            case (dir)
                ced_pkg::DIR_RIGHT:
                    if (cursor < ced_pkg::CUR_SEC_ONE) cursor = cursor + 3'd1;
                ced_pkg::DIR_LEFT:
                    if (cursor > ced_pkg::CUR_AMPM) cursor = cursor - 3'd1;
                ced_pkg::DIR_UP:    edit_digit(1);
                ced_pkg::DIR_DOWN:  edit_digit(-1);
                default: ;
            endcase
        end
        view.cursor            = cursor;
        view.pm                = pm;
        view.hours             = hours;
        view.minutes           = minutes;
        view.seconds           = seconds;
        view.applied_direction = dir;
        due.push_back(view);
    endfunction

    function void report(string what);
        $display("MISMATCH after %0d results: %s", checked, what);
        errors++;
    endfunction

    // Compare one result transfer with the oldest queued time
    function void check_result(t_time_view got);
        t_time_view want;
        if (due.size() == 0) begin
            report("result transfer with nothing outstanding");
            return;
        end
        want = due.pop_front();
        checked++;
        if (got.applied_direction != ced_pkg::DIR_NONE)
            applied++;
        if (got.cursor !== want.cursor)
            report($sformatf("cursor %0d, want %0d", got.cursor, want.cursor));
        if (got.pm !== want.pm)
            report($sformatf("pm %0d, want %0d", got.pm, want.pm));
        if (got.hours !== want.hours)
            report($sformatf("hours %0d, want %0d", got.hours, want.hours));
        if (got.minutes !== want.minutes)
            report($sformatf("minutes %0d, want %0d", got.minutes, want.minutes));
        if (got.seconds !== want.seconds)
            report($sformatf("seconds %0d, want %0d", got.seconds, want.seconds));
        if (got.applied_direction !== want.applied_direction)
            report($sformatf("direction %0d, want %0d", got.applied_direction,
                             want.applied_direction));
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 304;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic                      cfg_idx;
    logic [ced_pkg::THR_W-1:0] cfg_data;

    ced_in_if #(.ADC_BITS(ced_pkg::ADC_BITS)) in_ch();
    ced_out_if                                out_ch();

    clock_time_digit_editor_top #(.ADC_BITS(ced_pkg::ADC_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    time_edit_scoreboard board;
    int                  sent;
    int                  burst_left;
    int                  settings_run;
    int                  cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Cycle limit of %0d reached with %0d results outstanding",
                 CYCLE_LIMIT, board.due.size());
        $display("Verification failed");
        $finish;
    end

    // Result side stalls on a per-window mask
    initial begin : result_stall
        logic [31:0] mask;
        int          slot;
        mask = '1;
        slot = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (slot == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    mask = '1;
                    2:       mask = $urandom;
                    3:       mask = $urandom | $urandom;
                    default: mask = '1 << $urandom_range(1, 20);
                endcase
                if (mask == 0)
                    mask = 32'd1;
            end
            out_ch.ready <= mask[slot];
            slot = (slot + 1) % 32;
        end
    end

    // Note each input transfer in the model
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            board.note_input(in_ch.kind, in_ch.joy_x, in_ch.joy_y, in_ch.key_byte);
    end

    // Check each result transfer
    always @(posedge i_clk) begin
        t_time_view got;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.cursor            = out_ch.cursor;
            got.pm                = out_ch.pm;
            got.hours             = out_ch.hours;
            got.minutes           = out_ch.minutes;
            got.seconds           = out_ch.seconds;
            got.applied_direction = out_ch.applied_direction;
            board.check_result(got);
        end
    end

    // Drop valid between bursts
    task automatic pace();
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    // Hold one item until its transfer
    task automatic send_item(input logic kind, input logic [ced_pkg::ADC_BITS-1:0] x,
                             input logic [ced_pkg::ADC_BITS-1:0] y, input logic [7:0] key);
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.joy_x    <= x;
        in_ch.joy_y    <= y;
        in_ch.key_byte <= key;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sent++;
        pace();
    endtask

    task automatic send_key(input logic [7:0] key);
        send_item(ced_pkg::KIND_KEY, ced_pkg::ADC_BITS'($urandom),
                  ced_pkg::ADC_BITS'($urandom), key);
    endtask

    task automatic send_poll(input logic [ced_pkg::ADC_BITS-1:0] x,
                             input logic [ced_pkg::ADC_BITS-1:0] y);
        send_item(ced_pkg::KIND_POLL, x, y, 8'($urandom));
    endtask

    // Hold off input until every result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both thresholds on consecutive cycles
    task automatic program_thresholds(input logic [ced_pkg::THR_W-1:0] lo,
                                      input logic [ced_pkg::THR_W-1:0] hi);
        cfg_we   <= 1'b1;
        cfg_idx  <= ced_pkg::CFG_LOW_THR;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx  <= ced_pkg::CFG_HIGH_THR;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        board.low_thr  = lo;
        board.high_thr = hi;
        settings_run++;
    endtask

    // Sample biased towards the range ends and the threshold edges
    function automatic logic [ced_pkg::ADC_BITS-1:0] pick_sample();
        logic [ced_pkg::ADC_BITS-1:0] lo;
        logic [ced_pkg::ADC_BITS-1:0] hi;
        lo = board.low_thr;
        hi = board.high_thr;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return lo - 1'b1;
            3: return lo;
            4: return lo + 1'b1;
            5: return hi - 1'b1;
            6: return hi;
            7: return hi + 1'b1;
            8: begin
                if (hi > lo)
                    return lo + ced_pkg::ADC_BITS'($urandom_range(0, hi - lo));
                return ced_pkg::ADC_BITS'($urandom);
            end
            default: return ced_pkg::ADC_BITS'($urandom);
        endcase
    endfunction

    // Mostly direction keys and polls, some stray key bytes
    task automatic send_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            case ($urandom_range(0, 3))
                0:       send_key(ced_pkg::KEY_UP);
                1:       send_key(ced_pkg::KEY_DOWN);
                2:       send_key(ced_pkg::KEY_LEFT);
                default: send_key(ced_pkg::KEY_RIGHT);
            endcase
        end else if (roll < 45) begin
            send_key(8'($urandom));
        end else begin
            send_poll(pick_sample(), pick_sample());
        end
    endtask

    // Stimulus
    initial begin
        logic [ced_pkg::THR_W-1:0] lo_set [PHASES];
        logic [ced_pkg::THR_W-1:0] hi_set [PHASES];
        board          = new();
        sent           = 0;
        settings_run   = 1;
        burst_left     = $urandom_range(1, 30);
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= ced_pkg::CFG_LOW_THR;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= ced_pkg::KIND_POLL;
        in_ch.joy_x    <= '0;
        in_ch.joy_y    <= '0;
        in_ch.key_byte <= '0;

        lo_set = '{ced_pkg::LOW_THR_RST, 12'd0, 12'd4095, 12'd1500, 12'd2048,
                   12'($urandom)};
        hi_set = '{ced_pkg::HIGH_THR_RST, 12'd4095, 12'd0, 12'd2500, 12'd2048,
                   12'($urandom)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: joystick classes and priority, pending keys, cursor ends, wraps
        send_poll(12'd2000, 12'd2000);
        send_poll(12'd0, 12'd4095);
        send_poll(12'd2000, 12'd0);
        send_poll(12'd0, 12'd4095);
        send_poll(12'd4095, 12'd2000);
        send_key(ced_pkg::KEY_RIGHT);
        send_poll(12'd0, 12'd0);
        send_key(ced_pkg::KEY_UP);
        send_poll(12'd2000, 12'd2000);
        send_key(ced_pkg::KEY_DOWN);
        send_poll(12'd4095, 12'd4095);
        send_key(ced_pkg::KEY_LEFT);
        send_key(8'h00);
        send_key(8'hFF);
        send_poll(12'd2000, 12'd2000);
        send_poll(12'd2000, 12'd4095);
        send_poll(12'd2000, 12'd4095);
        send_poll(12'd4095, 12'd2000);
        repeat (7) send_poll(12'd2000, 12'd0);
        send_poll(12'd4095, 12'd2000);
        send_poll(12'd0, 12'd2000);

        // Random items under each threshold setting
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                program_thresholds(lo_set[phase], hi_set[phase]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain();
                send_random_item();
            end
        end

        drain();
        $display("Run covered %0d transfers under %0d threshold settings.",
                 sent, settings_run);
        $display("%0d results checked, %0d of them with a direction applied.",
                 board.checked, board.applied);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
